>>> sv/pdl_pkg.sv
// ----------------------------------------------------------------------------
// pdl_pkg: shared types and constants for Phong direct lighting
// Payload structs, normalizer control structs and register indexes.
// ----------------------------------------------------------------------------
package pdl_pkg;

   // One fixed-point one in Q2.14.
   localparam logic [14:0] ONE14 = 15'd16384;
   // Channel saturation ceiling.
   localparam logic [15:0] SAT16 = 16'hFFFF;

   // Configuration register indexes.
   localparam logic [2:0] CSR_OBS_X   = 3'd0;
   localparam logic [2:0] CSR_OBS_Y   = 3'd1;
   localparam logic [2:0] CSR_OBS_Z   = 3'd2;
   localparam logic [2:0] CSR_KD      = 3'd3;
   localparam logic [2:0] CSR_KS      = 3'd4;
   localparam logic [2:0] CSR_SHINE   = 3'd5;
   localparam logic [2:0] CSR_SURFACE = 3'd6;

   // Input item: one light seen from one shading point.
   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic signed [31:0] light_x;
      logic signed [31:0] light_y;
      logic signed [31:0] light_z;
      logic [47:0]        light_rgb;
      logic               occluded;
      logic               last_light;
   } req_type;

   // Result item: saturated channel sums.
   typedef struct packed {
      logic [15:0] direct_r;
      logic [15:0] direct_g;
      logic [15:0] direct_b;
   } rsp_type;

   // Request to the normalizer: start pulse and the vector to normalize.
   typedef struct packed {
      logic             start;
      logic [2:0][32:0] vec;
   } norm_req_type;

   // Answer from the normalizer: done pulse and the Q2.14 unit vector.
   typedef struct packed {
      logic             done;
      logic [2:0][15:0] unit;
   } norm_rsp_type;

endpackage

>>> sv/pdl_norm.sv
// ----------------------------------------------------------------------------
// pdl_norm: iterative vector normalizer
// Range shift, sum of squares, bit-serial square root and one restoring
// divider shared by the three components.
// ----------------------------------------------------------------------------
module pdl_norm (
   input  logic                  clock,
   input  logic                  reset,
   input  pdl_pkg::norm_req_type norm_req,
   output pdl_pkg::norm_rsp_type norm_rsp
);
   import pdl_pkg::*;

   localparam logic [2:0] N_IDLE  = 3'd0;
   localparam logic [2:0] N_SHIFT = 3'd1;
   localparam logic [2:0] N_SQ    = 3'd2;
   localparam logic [2:0] N_ROOT  = 3'd3;
   localparam logic [2:0] N_DIV   = 3'd4;

   logic [2:0]       st_ff, st_in;
   logic [2:0]       neg_ff, neg_in;
   logic [2:0][32:0] a_ff, a_in;
   logic [43:0]      sq_ff, sq_in;
   logic [43:0]      rv_ff, rv_in;
   logic [43:0]      res_ff, res_in;
   logic [43:0]      bit_ff, bit_in;
   logic [20:0]      len_ff, len_in;
   logic [20:0]      rem_ff, rem_in;
   logic [13:0]      q_ff, q_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic [1:0]       idx_ff, idx_in;
   logic [2:0][15:0] u_ff, u_in;
   logic             done_ff, done_in;

   logic [39:0] sqr;
   logic [43:0] trial;
   logic [21:0] shifted;
   logic        ge;
   logic [14:0] qfin, qc;

   assign sqr     = a_ff[idx_ff][19:0] * a_ff[idx_ff][19:0];
   assign trial   = res_ff + bit_ff;
   assign shifted = {rem_ff, (cnt_ff == 4'd0) ? a_ff[idx_ff][0] : 1'b0};
   assign ge      = shifted >= {1'b0, len_ff};
   assign qfin    = {q_ff, ge};
   assign qc      = (len_ff == 21'd0) ? 15'd0 : ((qfin > ONE14) ? ONE14 : qfin);

   // Sequencer for the normalization steps.
   always_comb begin
      st_in   = st_ff;
      neg_in  = neg_ff;
      a_in    = a_ff;
      sq_in   = sq_ff;
      rv_in   = rv_ff;
      res_in  = res_ff;
      bit_in  = bit_ff;
      len_in  = len_ff;
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      idx_in  = idx_ff;
      u_in    = u_ff;
      done_in = 1'b0;
      case (st_ff)
         N_IDLE: begin
            if (norm_req.start) begin
               for (int i = 0; i < 3; i++) begin
                  neg_in[i] = norm_req.vec[i][32];
                  a_in[i]   = norm_req.vec[i][32] ? (~norm_req.vec[i] + 33'd1)
                                                  : norm_req.vec[i];
               end
               st_in = N_SHIFT;
            end
         end
         N_SHIFT: begin
            if ((a_ff[0][32:20] | a_ff[1][32:20] | a_ff[2][32:20]) != 13'd0) begin
               for (int i = 0; i < 3; i++) a_in[i] = a_ff[i] >> 1;
            end else begin
               sq_in  = 44'd0;
               idx_in = 2'd0;
               st_in  = N_SQ;
            end
         end
         N_SQ: begin
            sq_in = sq_ff + 44'(sqr);
            if (idx_ff == 2'd2) begin
               rv_in  = sq_ff + 44'(sqr);
               res_in = 44'd0;
               bit_in = 44'd1 << 42;
               st_in  = N_ROOT;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         N_ROOT: begin
            if (rv_ff >= trial) begin
               rv_in  = rv_ff - trial;
               res_in = (res_ff >> 1) + bit_ff;
            end else begin
               res_in = res_ff >> 1;
            end
            bit_in = bit_ff >> 2;
            if (bit_ff[0]) begin
               len_in = res_in[20:0];
               idx_in = 2'd0;
               cnt_in = 4'd0;
               q_in   = 14'd0;
               rem_in = a_ff[0][20:0] >> 1;
               st_in  = N_DIV;
            end
         end
         N_DIV: begin
            rem_in = ge ? 21'(shifted - {1'b0, len_ff}) : shifted[20:0];
            q_in   = qfin[13:0];
            cnt_in = cnt_ff + 4'd1;
            if (cnt_ff == 4'd14) begin
               u_in[idx_ff] = neg_ff[idx_ff] ? 16'(-{1'b0, qc}) : {1'b0, qc};
               cnt_in = 4'd0;
               q_in   = 14'd0;
               if (idx_ff == 2'd2) begin
                  done_in = 1'b1;
                  st_in   = N_IDLE;
               end else begin
                  idx_in = idx_ff + 2'd1;
                  rem_in = a_ff[idx_ff + 2'd1][20:0] >> 1;
               end
            end
         end
         default: begin
            st_in = N_IDLE;
         end
      endcase
   end

   // State registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff   <= N_IDLE;
         done_ff <= 1'b0;
      end else begin
         st_ff   <= st_in;
         done_ff <= done_in;
      end
      neg_ff <= neg_in;
      a_ff   <= a_in;
      sq_ff  <= sq_in;
      rv_ff  <= rv_in;
      res_ff <= res_in;
      bit_ff <= bit_in;
      len_ff <= len_in;
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      idx_ff <= idx_in;
      u_ff   <= u_in;
   end

   assign norm_rsp.done = done_ff;
   assign norm_rsp.unit = u_ff;

endmodule

>>> sv/phong_direct_lighting.sv
// ----------------------------------------------------------------------------
// phong_direct_lighting: diffuse plus specular light accumulator
// Sequenced fixed-point Phong shading with one shared multiplier.
// ----------------------------------------------------------------------------
// Usage: each req_ transfer carries one light for one shading point. The
// block stalls req_ while it works and while a result waits on rsp_.
// A light that is not occluded goes through three vector normalizations
// (start handshake, range shift of up to 13 bits, 3 squares, 22 root
// steps, 45 divide steps and the done pulse), the steps of this
// sequencer and one step per unit of shininess. An occluded light skips
// all of that work. On the light that carries last_light the saturated
// RGB sums go to the rsp_ output register as the work ends, and the
// sums clear. rsp_ holds its transfer while rsp_stall is high; no new
// light is taken until that transfer is done.
// csr_ writes are always accepted and must come while the block is idle.
// Reset clears the sums, the sequencer and the registers (shininess to 1).
// ----------------------------------------------------------------------------
module phong_direct_lighting (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  pdl_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output pdl_pkg::rsp_type rsp_data,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [2:0]       csr_index,
   input  logic [47:0]      csr_data
);
   import pdl_pkg::*;

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_LS   = 4'd1;
   localparam logic [3:0] S_NL   = 4'd2;
   localparam logic [3:0] S_NDL  = 4'd3;
   localparam logic [3:0] S_DIF  = 4'd4;
   localparam logic [3:0] S_RV   = 4'd5;
   localparam logic [3:0] S_RS   = 4'd6;
   localparam logic [3:0] S_NR   = 4'd7;
   localparam logic [3:0] S_VS   = 4'd8;
   localparam logic [3:0] S_NV   = 4'd9;
   localparam logic [3:0] S_VR   = 4'd10;
   localparam logic [3:0] S_POW  = 4'd11;
   localparam logic [3:0] S_KS   = 4'd12;
   localparam logic [3:0] S_SPC  = 4'd13;
   localparam logic [3:0] S_FIN  = 4'd14;

   logic [3:0]         state_ff, state_in;
   req_type            item_ff, item_in;
   logic [2:0][15:0]   l_ff, l_in, r_ff, r_in, v_ff, v_in;
   logic [2:0][32:0]   d_ff, d_in;
   logic signed [34:0] dot_ff, dot_in;
   logic signed [17:0] ndl_ff, ndl_in;
   logic [14:0]        vv_ff, vv_in, pw_ff, pw_in;
   logic [27:0]        t_ff, t_in;
   logic [7:0]         cnt_ff, cnt_in;
   logic [1:0]         idx_ff, idx_in, step_ff, step_in;
   logic [2:0][15:0]   sum_ff, sum_in;
   logic signed [31:0] obs_x_ff, obs_x_in, obs_y_ff, obs_y_in, obs_z_ff, obs_z_in;
   logic [15:0]        kd_ff, kd_in, ks_ff, ks_in;
   logic [7:0]         shine_ff, shine_in;
   logic [47:0]        surf_ff, surf_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_data_ff, rsp_data_in;

   norm_req_type       norm_req;
   norm_rsp_type       norm_rsp;

   logic signed [24:0] mul_a, mul_b;
   logic signed [49:0] prod;
   logic signed [34:0] dot_total;
   logic signed [17:0] dot_q14;
   logic               accept;

   // Pick one 16-bit channel from a packed RGB word, red first.
   function automatic logic [15:0] chan(input logic [47:0] packed_rgb,
                                        input logic [1:0] k);
      logic [15:0] c;
      case (k)
         2'd0:    c = packed_rgb[47:32];
         2'd1:    c = packed_rgb[31:16];
         default: c = packed_rgb[15:0];
      endcase
      return c;
   endfunction

   // Add into a channel sum, saturating at the top of the range.
   function automatic logic [15:0] sat_add(input logic [15:0] acc,
                                           input logic [27:0] val);
      logic [28:0] t;
      t = {13'd0, acc} + {1'b0, val};
      return (t > 29'(SAT16)) ? SAT16 : t[15:0];
   endfunction

   // Component selects for the dot products and the reflection.
   function automatic logic [15:0] nsel(input req_type it, input logic [1:0] k);
      logic [15:0] c;
      case (k)
         2'd0:    c = it.normal_x;
         2'd1:    c = it.normal_y;
         default: c = it.normal_z;
      endcase
      return c;
   endfunction

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign csr_ready = 1'b1;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Shared multiplier operand selection.
   always_comb begin
      mul_a = 25'sd0;
      mul_b = 25'sd0;
      case (state_ff)
         S_NDL: begin
            mul_a = 25'($signed(nsel(item_ff, idx_ff)));
            mul_b = 25'($signed(l_ff[idx_ff]));
         end
         S_DIF: begin
            case (step_ff)
               2'd0: begin
                  mul_a = $signed({9'd0, kd_ff});
                  mul_b = $signed({9'd0, chan(surf_ff, idx_ff)});
               end
               2'd1: begin
                  mul_a = $signed({1'b0, t_ff[23:0]});
                  mul_b = 25'(ndl_ff);
               end
               default: begin
                  mul_a = $signed({1'b0, t_ff[23:0]});
                  mul_b = $signed({9'd0, chan(item_ff.light_rgb, idx_ff)});
               end
            endcase
         end
         S_RV: begin
            mul_a = 25'($signed(nsel(item_ff, idx_ff)));
            mul_b = 25'(ndl_ff);
         end
         S_VR: begin
            mul_a = 25'($signed(v_ff[idx_ff]));
            mul_b = 25'($signed(r_ff[idx_ff]));
         end
         S_POW: begin
            mul_a = $signed({10'd0, pw_ff});
            mul_b = $signed({10'd0, vv_ff});
         end
         S_KS: begin
            mul_a = $signed({9'd0, ks_ff});
            mul_b = $signed({10'd0, pw_ff});
         end
         S_SPC: begin
            mul_a = $signed({1'b0, t_ff[23:0]});
            mul_b = $signed({9'd0, chan(item_ff.light_rgb, idx_ff)});
         end
         default: begin
            mul_a = 25'sd0;
            mul_b = 25'sd0;
         end
      endcase
   end

   assign prod      = mul_a * mul_b;
   assign dot_total = dot_ff + 35'(prod);
   assign dot_q14   = dot_total[31:14];

   // Normalizer control.
   assign norm_req.start = (state_ff == S_LS) || (state_ff == S_RS) ||
                           (state_ff == S_VS);
   assign norm_req.vec   = d_ff;

   pdl_norm u_norm (
      .clock    (clock),
      .reset    (reset),
      .norm_req (norm_req),
      .norm_rsp (norm_rsp)
   );

   // Sequencer and configuration writes.
   always_comb begin
      state_in     = state_ff;
      item_in      = item_ff;
      l_in         = l_ff;
      r_in         = r_ff;
      v_in         = v_ff;
      d_in         = d_ff;
      dot_in       = dot_ff;
      ndl_in       = ndl_ff;
      vv_in        = vv_ff;
      pw_in        = pw_ff;
      t_in         = t_ff;
      cnt_in       = cnt_ff;
      idx_in       = idx_ff;
      step_in      = step_ff;
      sum_in       = sum_ff;
      obs_x_in     = obs_x_ff;
      obs_y_in     = obs_y_ff;
      obs_z_in     = obs_z_ff;
      kd_in        = kd_ff;
      ks_in        = ks_ff;
      shine_in     = shine_ff;
      surf_in      = surf_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;

      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_OBS_X:   obs_x_in = csr_data[31:0];
            CSR_OBS_Y:   obs_y_in = csr_data[31:0];
            CSR_OBS_Z:   obs_z_in = csr_data[31:0];
            CSR_KD:      kd_in    = csr_data[15:0];
            CSR_KS:      ks_in    = csr_data[15:0];
            CSR_SHINE:   shine_in = csr_data[7:0];
            CSR_SURFACE: surf_in  = csr_data;
            default:     ;
         endcase
      end

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               item_in = req_data;
               d_in[0] = 33'(req_data.light_x) - 33'(req_data.point_x);
               d_in[1] = 33'(req_data.light_y) - 33'(req_data.point_y);
               d_in[2] = 33'(req_data.light_z) - 33'(req_data.point_z);
               state_in = req_data.occluded ? S_FIN : S_LS;
            end
         end
         S_LS: state_in = S_NL;
         S_NL: begin
            if (norm_rsp.done) begin
               l_in     = norm_rsp.unit;
               idx_in   = 2'd0;
               dot_in   = 35'sd0;
               state_in = S_NDL;
            end
         end
         S_NDL: begin
            dot_in = dot_total;
            if (idx_ff == 2'd2) begin
               ndl_in   = dot_q14;
               idx_in   = 2'd0;
               step_in  = 2'd0;
               state_in = (dot_q14 > 18'sd0) ? S_DIF : S_RV;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         S_DIF: begin
            case (step_ff)
               2'd0: begin
                  t_in    = {8'd0, prod[31:12]};
                  step_in = 2'd1;
               end
               2'd1: begin
                  t_in    = {5'd0, prod[36:14]};
                  step_in = 2'd2;
               end
               default: begin
                  sum_in[idx_ff] = sat_add(sum_ff[idx_ff], prod[39:12]);
                  step_in = 2'd0;
                  if (idx_ff == 2'd2) begin
                     idx_in   = 2'd0;
                     state_in = S_RV;
                  end else begin
                     idx_in = idx_ff + 2'd1;
                  end
               end
            endcase
         end
         S_RV: begin
            d_in[idx_ff] = 33'($signed(prod[33:13])) - 33'($signed(l_ff[idx_ff]));
            if (idx_ff == 2'd2) begin
               idx_in   = 2'd0;
               state_in = S_RS;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         S_RS: state_in = S_NR;
         S_NR: begin
            if (norm_rsp.done) begin
               r_in     = norm_rsp.unit;
               d_in[0]  = 33'(obs_x_ff) - 33'(item_ff.point_x);
               d_in[1]  = 33'(obs_y_ff) - 33'(item_ff.point_y);
               d_in[2]  = 33'(obs_z_ff) - 33'(item_ff.point_z);
               state_in = S_VS;
            end
         end
         S_VS: state_in = S_NV;
         S_NV: begin
            if (norm_rsp.done) begin
               v_in     = norm_rsp.unit;
               idx_in   = 2'd0;
               dot_in   = 35'sd0;
               state_in = S_VR;
            end
         end
         S_VR: begin
            dot_in = dot_total;
            if (idx_ff == 2'd2) begin
               idx_in = 2'd0;
               if (dot_q14 > 18'sd0) begin
                  vv_in    = (dot_q14 > 18'sd16384) ? ONE14 : dot_q14[14:0];
                  pw_in    = ONE14;
                  cnt_in   = shine_ff;
                  state_in = S_POW;
               end else begin
                  state_in = S_FIN;
               end
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         S_POW: begin
            if (cnt_ff == 8'd0) begin
               state_in = S_KS;
            end else begin
               pw_in  = prod[28:14];
               cnt_in = cnt_ff - 8'd1;
            end
         end
         S_KS: begin
            t_in     = {12'd0, prod[29:14]};
            idx_in   = 2'd0;
            state_in = S_SPC;
         end
         S_SPC: begin
            sum_in[idx_ff] = sat_add(sum_ff[idx_ff], prod[39:12]);
            if (idx_ff == 2'd2) begin
               idx_in   = 2'd0;
               state_in = S_FIN;
            end else begin
               idx_in = idx_ff + 2'd1;
            end
         end
         S_FIN: begin
            if (item_ff.last_light) begin
               rsp_data_in.direct_r = sum_ff[0];
               rsp_data_in.direct_g = sum_ff[1];
               rsp_data_in.direct_b = sum_ff[2];
               rsp_valid_in         = 1'b1;
               sum_in               = '0;
            end
            state_in = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         sum_ff       <= '0;
         obs_x_ff     <= 32'sd0;
         obs_y_ff     <= 32'sd0;
         obs_z_ff     <= 32'sd0;
         kd_ff        <= 16'd0;
         ks_ff        <= 16'd0;
         shine_ff     <= 8'd1;
         surf_ff      <= 48'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sum_ff       <= sum_in;
         obs_x_ff     <= obs_x_in;
         obs_y_ff     <= obs_y_in;
         obs_z_ff     <= obs_z_in;
         kd_ff        <= kd_in;
         ks_ff        <= ks_in;
         shine_ff     <= shine_in;
         surf_ff      <= surf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      item_ff     <= item_in;
      l_ff        <= l_in;
      r_ff        <= r_in;
      v_ff        <= v_in;
      d_ff        <= d_in;
      dot_ff      <= dot_in;
      ndl_ff      <= ndl_in;
      vv_ff       <= vv_in;
      pw_ff       <= pw_in;
      t_ff        <= t_in;
      cnt_ff      <= cnt_in;
      idx_ff      <= idx_in;
      step_ff     <= step_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

>>> sv/pdl_checker.sv
// ----------------------------------------------------------------------------
// pdl_checker: port-level assertions for phong_direct_lighting
// Watches the channels over time and is bound to the top level.
// ----------------------------------------------------------------------------
module pdl_checker (
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_stall,
   input logic             rsp_valid,
   input logic             rsp_stall,
   input pdl_pkg::rsp_type rsp_data
);
   import pdl_pkg::*;

   // A stalled result holds its value until the transfer.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("result changed while stalled");

   // No result is pending right after reset.
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // Each accepted light keeps the block busy on the next cycle.
   a_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("input taken back to back");

   // A waiting result blocks new lights.
   a_rsp_blocks: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input open while a result waits");

endmodule

bind phong_direct_lighting pdl_checker u_pdl_checker (.*);

>>> tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench: self-checking bench for phong_direct_lighting
// A queue-fed driver offers lights and a clocked monitor compares each
// emitted color against an in-bench fixed-point Phong predictor.
// ----------------------------------------------------------------------------
module testbench;
   import pdl_pkg::*;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;
   logic    csr_valid;
   logic    csr_ready;
   logic [2:0]  csr_index;
   logic [47:0] csr_data;

   phong_direct_lighting u_dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_index(csr_index), .csr_data(csr_data)
   );

   // Clock with a 4 ns period.
   always begin
      clock = 1'b1;
      #2;
      clock = 1'b0;
      #2;
   end

   // Shadow copy of the material and viewer registers.
   logic signed [31:0] view_x, view_y, view_z;
   logic [15:0] kd, ks;
   logic [7:0]  shine;
   logic [47:0] surface;
   logic [15:0] acc_r, acc_g, acc_b;

   req_type light_queue[$];
   rsp_type color_queue[$];
   int  errors;
   bit  all_sent;
   bit  hold_rsp;
   bit  req_taken;
   int  idle_cycles;

   // Integer square root, floor.
   function automatic longint unsigned isqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = 64'd1 << 62;
      while (bitv > v) bitv = bitv >> 2;
      while (bitv != 0) begin
         if (v >= res + bitv) begin
            v = v - (res + bitv);
            res = (res >> 1) + bitv;
         end else begin
            res = res >> 1;
         end
         bitv = bitv >> 2;
      end
      return res;
   endfunction

   // Scale to Q2.14 unit length, range-shifting large components first.
   function automatic void unit_vec(input longint d[3], output longint u[3]);
      longint unsigned a[3], m, sum, len, q;
      int s;
      m = 0;
      sum = 0;
      s = 0;
      for (int i = 0; i < 3; i++) begin
         a[i] = d[i] < 0 ? -d[i] : d[i];
         if (a[i] > m) m = a[i];
      end
      while ((m >> s) >= (64'd1 << 20)) s++;
      for (int i = 0; i < 3; i++) begin
         a[i] = a[i] >> s;
         sum += a[i] * a[i];
      end
      len = isqrt(sum);
      for (int i = 0; i < 3; i++) begin
         q = 0;
         if (len != 0) begin
            q = (a[i] * 16384) / len;
            if (q > 16384) q = 16384;
         end
         u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
      end
   endfunction

   function automatic longint dot_q14(longint a[3], longint b[3]);
      return (a[0] * b[0] + a[1] * b[1] + a[2] * b[2]) >>> 14;
   endfunction

   function automatic logic [15:0] sat_sum(logic [15:0] s, longint unsigned v);
      longint unsigned t;
      t = s + v;
      return t > 65535 ? 16'hFFFF : t[15:0];
   endfunction

   // Shade one light into the running sums; queue a color on the last one.
   task automatic shade_light(req_type it);
      longint p[3], n[3], d[3], l[3], r[3], v[3];
      longint ndl, vr;
      longint unsigned ch[3], sc[3], a, b, pw, vv, sp;
      logic [15:0] acc[3];
      rsp_type c;
      acc = '{acc_r, acc_g, acc_b};
      if (!it.occluded) begin
         p = '{it.point_x, it.point_y, it.point_z};
         n = '{it.normal_x, it.normal_y, it.normal_z};
         d[0] = longint'(it.light_x) - p[0];
         d[1] = longint'(it.light_y) - p[1];
         d[2] = longint'(it.light_z) - p[2];
         ch = '{it.light_rgb[47:32], it.light_rgb[31:16], it.light_rgb[15:0]};
         sc = '{surface[47:32], surface[31:16], surface[15:0]};
         unit_vec(d, l);
         ndl = dot_q14(n, l);
         if (ndl > 0) begin
            for (int i = 0; i < 3; i++) begin
               a = (longint'(kd) * sc[i]) >> 12;
               b = (a * ndl) >> 14;
               acc[i] = sat_sum(acc[i], (b * ch[i]) >> 12);
            end
         end
         for (int i = 0; i < 3; i++) d[i] = ((2 * n[i] * ndl) >>> 14) - l[i];
         unit_vec(d, r);
         d[0] = longint'(view_x) - p[0];
         d[1] = longint'(view_y) - p[1];
         d[2] = longint'(view_z) - p[2];
         unit_vec(d, v);
         vr = dot_q14(v, r);
         if (vr > 0) begin
            pw = 16384;
            vv = vr > 16384 ? 16384 : vr;
            for (int k = 0; k < shine; k++) pw = (pw * vv) >> 14;
            sp = (longint'(ks) * pw) >> 14;
            for (int i = 0; i < 3; i++) acc[i] = sat_sum(acc[i], (sp * ch[i]) >> 12);
         end
      end
      acc_r = acc[0];
      acc_g = acc[1];
      acc_b = acc[2];
      if (it.last_light) begin
         c.direct_r = acc_r;
         c.direct_g = acc_g;
         c.direct_b = acc_b;
         color_queue.push_back(c);
         acc_r = 0;
         acc_g = 0;
         acc_b = 0;
      end
   endtask

   // Gap length: mostly short, now and then long.
   function automatic int gap_len();
      int k;
      k = $urandom_range(0, 99);
      if (k < 50) return 0;
      if (k < 92) return $urandom_range(1, 4);
      return $urandom_range(20, 200);
   endfunction

   function automatic logic [31:0] rand_coord();
      case ($urandom_range(0, 4))
         0: return $urandom;
         1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: return {{12{1'b0}}, 20'($urandom)} - 32'h0008_0000;
      endcase
   endfunction

   function automatic logic [15:0] rand_norm();
      case ($urandom_range(0, 9))
         0: return 16'($urandom);
         1: return $urandom_range(0, 1) ? 16'sd16384 : -16'sd16384;
         default: return 16'($urandom_range(0, 32768)) - 16'd16384;
      endcase
   endfunction

   function automatic req_type rand_light(bit last);
      req_type it;
      it.point_x = rand_coord();
      it.point_y = rand_coord();
      it.point_z = rand_coord();
      it.normal_x = rand_norm();
      it.normal_y = rand_norm();
      it.normal_z = rand_norm();
      it.light_x = rand_coord();
      it.light_y = rand_coord();
      it.light_z = rand_coord();
      it.light_rgb = {16'($urandom), 16'($urandom), 16'($urandom)};
      it.occluded = ($urandom_range(0, 5) == 0);
      it.last_light = last;
      return it;
   endfunction

   // Register write, held until it is accepted; also updates the shadow copy.
   task automatic write_reg(logic [2:0] idx, logic [47:0] val);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= val;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      case (idx)
         CSR_OBS_X:   view_x = val[31:0];
         CSR_OBS_Y:   view_y = val[31:0];
         CSR_OBS_Z:   view_z = val[31:0];
         CSR_KD:      kd = val[15:0];
         CSR_KS:      ks = val[15:0];
         CSR_SHINE:   shine = val[7:0];
         CSR_SURFACE: surface = val;
         default: ;
      endcase
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic set_material(logic [31:0] ox, logic [31:0] oy, logic [31:0] oz,
                               logic [15:0] kdv, logic [15:0] ksv, logic [7:0] sh,
                               logic [47:0] srf);
      write_reg(CSR_OBS_X, {16'd0, ox});
      write_reg(CSR_OBS_Y, {16'd0, oy});
      write_reg(CSR_OBS_Z, {16'd0, oz});
      write_reg(CSR_KD, {32'd0, kdv});
      write_reg(CSR_KS, {32'd0, ksv});
      write_reg(CSR_SHINE, {40'd0, sh});
      write_reg(CSR_SURFACE, srf);
   endtask

   // Wait until every light is taken and every color has come out.
   task automatic drain();
      while (light_queue.size() != 0 || req_valid || color_queue.size() != 0)
         @(posedge clock);
      repeat (600) @(posedge clock);
   endtask

   // Driver: offers the head of the pending lights, changing at the falling edge.
   int send_gap;
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap <= 0;
      end else if (req_valid && !req_taken) begin
         // Hold the offered light until its transfer.
      end else if (send_gap > 0) begin
         req_valid <= 1'b0;
         send_gap <= send_gap - 1;
      end else if (light_queue.size() != 0) begin
         req_data <= light_queue.pop_front();
         req_valid <= 1'b1;
         send_gap <= gap_len();
      end else begin
         req_valid <= 1'b0;
      end
   end

   // Predict at the accepting edge so the expected color is queued first.
   always @(posedge clock) begin
      req_taken = !reset && req_valid && !req_stall;
      if (req_taken) shade_light(req_data);
   end

   // Receiver stall pattern, with a forced long hold-off when asked.
   int stall_left;
   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left <= 0;
      end else if (hold_rsp) begin
         rsp_stall <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= gap_len();
      end
   end

   // Monitor: compare each transferred color with the oldest prediction.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (color_queue.size() == 0) begin
            $error("unexpected color transfer %h", rsp_data);
            errors++;
         end else begin
            want = color_queue.pop_front();
            if (rsp_data.direct_r !== want.direct_r) begin
               $error("direct_r expected %h got %h", want.direct_r, rsp_data.direct_r);
               errors++;
            end
            if (rsp_data.direct_g !== want.direct_g) begin
               $error("direct_g expected %h got %h", want.direct_g, rsp_data.direct_g);
               errors++;
            end
            if (rsp_data.direct_b !== want.direct_b) begin
               $error("direct_b expected %h got %h", want.direct_b, rsp_data.direct_b);
               errors++;
            end
         end
      end
   end

   // Watchdog: stops the run and reports errors once the idle count passes its limit.
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
          || (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else begin
         idle_cycles <= idle_cycles + 1;
         if (idle_cycles > 20000) begin
            $display("testbench: done, errors");
            $finish;
         end
      end
   end

   initial begin
      req_type it;
      int nlights;
      errors = 0;
      all_sent = 0;
      hold_rsp = 0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_data = '0;
      rsp_stall = 1'b0;
      csr_valid = 1'b0;
      csr_index = '0;
      csr_data = '0;
      view_x = 0;
      view_y = 0;
      view_z = 0;
      kd = 0;
      ks = 0;
      shine = 1;
      surface = 0;
      acc_r = 0;
      acc_g = 0;
      acc_b = 0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed lights with a moderate material, viewer above the origin.
      set_material(32'h000A_0000, 32'h0005_0000, 32'h0010_0000, 16'h0C00, 16'h0800,
                   8'd8, {16'h1000, 16'h0800, 16'h0400});
      it = '0;
      it.normal_z = 16'sd16384;
      it.light_z = 32'h0008_0000;
      it.light_rgb = {16'h1000, 16'h1000, 16'h1000};
      it.last_light = 1;
      light_queue.push_back(it);           // light straight above
      it.light_z = 0;
      light_queue.push_back(it);           // light at the point: zero length
      it.light_z = -32'sh0008_0000;
      light_queue.push_back(it);           // light behind the surface
      it.light_z = 32'h0008_0000;
      it.normal_x = 16'h7FFF;
      it.normal_z = 16'h8000;
      light_queue.push_back(it);           // normal beyond unit range
      it.normal_x = 0;
      it.normal_z = 16'sd16384;
      it.occluded = 1;
      light_queue.push_back(it);           // occluded last light
      it.occluded = 0;
      it.last_light = 0;
      it.light_rgb = '1;
      repeat (3) light_queue.push_back(it); // saturating sums
      it.last_light = 1;
      it.point_x = 32'h7FFF_FFFF;
      it.point_y = 32'h8000_0000;
      it.light_x = 32'h8000_0000;
      it.light_y = 32'h7FFF_FFFF;
      light_queue.push_back(it);           // extreme coordinates
      drain();

      // Shininess zero, viewer at the origin.
      set_material(32'd0, 32'd0, 32'd0, 16'hFFFF, 16'hFFFF, 8'd0, '1);
      for (int i = 0; i < 6; i++) light_queue.push_back(rand_light(1'(i % 2)));
      drain();

      // Random phases over several material settings.
      for (int ph = 0; ph < 5; ph++) begin
         case (ph)
            0: set_material(rand_coord(), rand_coord(), rand_coord(), 16'h1000,
                            16'h1000, 8'd255, {16'h1000, 16'h1000, 16'h1000});
            1: set_material(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'd0, 16'd0,
                            8'd1, 48'd0);
            default: set_material(rand_coord(), rand_coord(), rand_coord(),
                                  16'($urandom), 16'($urandom),
                                  8'($urandom_range(0, 24)),
                                  {16'($urandom), 16'($urandom), 16'($urandom)});
         endcase
         nlights = 0;
         while (nlights < 120) begin
            int group;
            group = $urandom_range(1, 4);
            for (int g = 0; g < group; g++)
               light_queue.push_back(rand_light(g == group - 1 || $urandom_range(0, 9) == 0));
            nlights += group;
         end
         // Receiver holds off long while the sender keeps offering.
         if (ph == 2) begin
            hold_rsp = 1;
            repeat (3000) @(posedge clock);
            hold_rsp = 0;
         end
         drain();
      end

      if (errors == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
